// File: hw/rtl/rpu_pkg.sv
package rpu_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned PixW   = 14;
  localparam int unsigned OutW   = 17;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;
  localparam int unsigned PhaseW = 3;

  localparam logic [PhaseW-1:0] LastPhase   = 3'd6;
  localparam logic [PixW-1:0]   PixMask     = 14'h3FFF;
  localparam logic [OutW-1:0]   LevelOffset = 17'd15;
  localparam logic [WordW-1:0]  BlackReset  = 16'd2000;

  localparam logic [1:0] RegSixteenBitMode = 2'd0;
  localparam logic [1:0] RegSwapBytes      = 2'd1;
  localparam logic [1:0] RegBlackLevel     = 2'd2;
  localparam logic [1:0] RegLevelAdjust    = 2'd3;

  typedef struct packed {
    logic             sixteen_bit_mode;
    logic             swap_bytes;
    logic [WordW-1:0] black_level;
    logic             level_adjust;
  } cfg_t;

  typedef struct packed {
    logic             clr_history;
    logic             last;
    logic [WordW-1:0] raw;
  } entry_t;

endpackage

// File: hw/rtl/rpu_front.sv
module rpu_front (
  input  logic                       clk,
  input  logic                       rst,
  input  rpu_pkg::cfg_t              cfg,
  input  logic                       word_valid,
  output logic                       word_stall,
  input  logic [rpu_pkg::WordW-1:0]  packed_word,
  input  logic                       start_of_frame,
  output logic                       push,
  output rpu_pkg::entry_t            push_entry,
  input  logic                       q_full
);

  logic [rpu_pkg::PhaseW-1:0] bit_phase;
  logic [rpu_pkg::PhaseW-1:0] bit_phase_next;
  logic [rpu_pkg::PixW-1:0]   leftover_bits;
  logic [rpu_pkg::PixW-1:0]   leftover_bits_next;
  logic                       pend_valid;
  logic [rpu_pkg::PixW-1:0]   pend_raw;

  logic                       accept;
  logic [rpu_pkg::WordW-1:0]  w;
  logic [rpu_pkg::PhaseW-1:0] phase;
  logic [rpu_pkg::PixW-1:0]   left;
  logic [3:0]                 shift;
  logic [29:0]                acc;
  logic [rpu_pkg::PixW-1:0]   raw0;
  logic [rpu_pkg::PixW-1:0]   rest;
  logic                       split;

  assign word_stall = pend_valid | q_full;
  assign accept     = word_valid & ~word_stall;

  always_comb begin
    w = cfg.swap_bytes ? {packed_word[7:0], packed_word[15:8]} : packed_word;
    phase = bit_phase;
    if (start_of_frame || bit_phase > rpu_pkg::LastPhase) begin
      phase = '0;
    end
    left  = start_of_frame ? '0 : leftover_bits;
    shift = {phase, 1'b0} + 4'd2;
    acc   = {left, w};
    raw0  = rpu_pkg::PixW'(acc >> shift) & rpu_pkg::PixMask;
    rest  = rpu_pkg::PixW'(w & ~(16'hFFFF << shift));
    split = ~cfg.sixteen_bit_mode & (phase == rpu_pkg::LastPhase);
  end

  always_comb begin
    bit_phase_next     = bit_phase;
    leftover_bits_next = leftover_bits;
    if (accept) begin
      if (cfg.sixteen_bit_mode) begin
        if (start_of_frame) begin
          bit_phase_next     = '0;
          leftover_bits_next = '0;
        end
      end else if (split) begin
        bit_phase_next     = '0;
        leftover_bits_next = '0;
      end else begin
        bit_phase_next     = phase + 3'd1;
        leftover_bits_next = rest;
      end
    end
  end

  always_comb begin
    push_entry.clr_history = 1'b0;
    push_entry.last        = 1'b1;
    push_entry.raw         = {2'b00, pend_raw};
    push                   = 1'b0;
    if (pend_valid) begin
      push = ~q_full;
    end else if (accept) begin
      push                   = 1'b1;
      push_entry.clr_history = start_of_frame;
      push_entry.last        = ~split;
      push_entry.raw         = cfg.sixteen_bit_mode ? w : {2'b00, raw0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_phase     <= '0;
      leftover_bits <= '0;
      pend_valid    <= 1'b0;
    end else begin
      bit_phase     <= bit_phase_next;
      leftover_bits <= leftover_bits_next;
      if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end else if (accept && split) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && split) begin
      pend_raw <= rest;
    end
  end

endmodule

// File: hw/rtl/rpu_queue.sv
module rpu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rpu_pkg::entry_t push_entry,
  output logic            q_full,
  input  logic            pop,
  output logic            q_empty,
  output rpu_pkg::entry_t head
);

  rpu_pkg::entry_t          mem [rpu_pkg::QDepth];
  logic [rpu_pkg::QAw-1:0]  wr_ptr;
  logic [rpu_pkg::QAw-1:0]  rd_ptr;
  logic [rpu_pkg::QAw:0]    count;

  assign q_full  = (count == (rpu_pkg::QAw+1)'(rpu_pkg::QDepth));
  assign q_empty = (count == '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: hw/rtl/rpu_back.sv
module rpu_back (
  input  logic                      clk,
  input  logic                      rst,
  input  rpu_pkg::cfg_t             cfg,
  input  logic                      q_empty,
  input  rpu_pkg::entry_t           head,
  output logic                      pop,
  output logic                      pixel_valid,
  input  logic                      pixel_stall,
  output logic [rpu_pkg::OutW-1:0]  pixel_value,
  output logic                      last_of_word
);

  logic [rpu_pkg::OutW-1:0] recent0;
  logic [rpu_pkg::OutW-1:0] recent1;
  logic [rpu_pkg::OutW-1:0] older;
  logic [rpu_pkg::OutW-1:0] newer;
  logic [rpu_pkg::OutW-1:0] value;

  assign pop = ~q_empty & (~pixel_valid | ~pixel_stall);

  always_comb begin
    older = head.clr_history ? '0 : recent1;
    newer = head.clr_history ? '0 : recent0;
    if (head.raw == '0) begin
      value = older;
    end else if (cfg.level_adjust) begin
      if (head.raw >= cfg.black_level) begin
        value = {1'b0, head.raw - cfg.black_level} + rpu_pkg::LevelOffset;
      end else begin
        value = rpu_pkg::LevelOffset;
      end
    end else begin
      value = {1'b0, head.raw};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      recent0     <= '0;
      recent1     <= '0;
    end else begin
      if (pop) begin
        pixel_valid <= 1'b1;
        recent1     <= newer;
        recent0     <= value;
      end else if (!pixel_stall) begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pixel_value  <= value;
      last_of_word <= head.last;
    end
  end

endmodule

// File: hw/rtl/raw_pixel_unpack_black_level.sv
// Unpacks a raw sensor word stream into pixels, masks dead (zero) pixels with the
// pixel two places back and optionally subtracts the black level with an offset of 15.
// One word is taken per cycle while the queue has room; a word at group position
// six of the 14-bit packing yields two pixels and holds the word input while the
// second pixel enters the four-entry queue. 16-bit data runs at one word per cycle
// while the queue has room. Each pixel is registered in the queue and at the output.
// Registers lie at byte addresses 0 (mode), 4 (swap), 8 (black level), 12 (adjust);
// the user must write them only while the block is idle; it is not enforced.
module raw_pixel_unpack_black_level (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               word_valid,
  output logic                               word_stall,
  input  logic [rpu_pkg::WordW-1:0]          packed_word,
  input  logic                               start_of_frame,
  output logic                               pixel_valid,
  input  logic                               pixel_stall,
  output logic [rpu_pkg::OutW-1:0]           pixel_value,
  output logic                               last_of_word,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rpu_pkg::AddrW-1:0]          paddr,
  input  logic [rpu_pkg::DataW-1:0]          pwdata,
  output logic [rpu_pkg::DataW-1:0]          prdata,
  output logic                               pready
);

  rpu_pkg::cfg_t   cfg;
  rpu_pkg::entry_t push_entry;
  rpu_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sixteen_bit_mode <= 1'b0;
      cfg.swap_bytes       <= 1'b0;
      cfg.black_level      <= rpu_pkg::BlackReset;
      cfg.level_adjust     <= 1'b1;
    end else if (wr_en) begin
      case (paddr[3:2])
        rpu_pkg::RegSixteenBitMode: cfg.sixteen_bit_mode <= pwdata[0];
        rpu_pkg::RegSwapBytes:      cfg.swap_bytes       <= pwdata[0];
        rpu_pkg::RegBlackLevel:     cfg.black_level      <= pwdata[15:0];
        rpu_pkg::RegLevelAdjust:    cfg.level_adjust     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rpu_pkg::RegSixteenBitMode: prdata = {31'd0, cfg.sixteen_bit_mode};
      rpu_pkg::RegSwapBytes:      prdata = {31'd0, cfg.swap_bytes};
      rpu_pkg::RegBlackLevel:     prdata = {16'd0, cfg.black_level};
      rpu_pkg::RegLevelAdjust:    prdata = {31'd0, cfg.level_adjust};
      default:                    prdata = '0;
    endcase
  end

  rpu_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .word_valid     (word_valid),
    .word_stall     (word_stall),
    .packed_word    (packed_word),
    .start_of_frame (start_of_frame),
    .push           (push),
    .push_entry     (push_entry),
    .q_full         (q_full)
  );

  rpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_full     (q_full),
    .pop        (pop),
    .q_empty    (q_empty),
    .head       (head)
  );

  rpu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .head         (head),
    .pop          (pop),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_value  (pixel_value),
    .last_of_word (last_of_word)
  );

endmodule

// File: hw/rtl/rpu_checker.sv
module rpu_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      pixel_valid,
  input logic                      pixel_stall,
  input logic [rpu_pkg::OutW-1:0]  pixel_value,
  input logic                      last_of_word
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_value) && $stable(last_of_word))
    else $error("stalled pixel request changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pixel_valid)
    else $error("pixel request right after reset");

  a_range: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> pixel_value <= 17'd65550)
    else $error("pixel value out of range");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_stall && !last_of_word |=> pixel_valid)
    else $error("second pixel of a word did not follow");

endmodule

bind raw_pixel_unpack_black_level rpu_checker u_rpu_checker (.*);
